### src/bcr_pkg.sv
// ----------------------------------------------------------------------------
// bcr_pkg: shared definitions of the Brooks-Corey relative permeability core
// Default formats, region codes, register indexes and the constant roots used
// by the exp2 stages.
// ----------------------------------------------------------------------------
package bcr_pkg;

   localparam int FRAC_BITS_DEF     = 16;
   localparam int EXP_FRAC_BITS_DEF = 12;

   // Number of log2 fraction bits, one squaring stage each.
   localparam int LOG_BITS  = 24;
   // Working mantissa is Q2.30.
   localparam int MANT_W    = 32;
   localparam int MANT_FRAC = 30;
   // Normalise, log stages, exponent product, exp2 stages, shift, scale.
   localparam int POW_LAT   = 2 * LOG_BITS + 4;

   localparam logic [1:0] REGION_INTERIOR = 2'd0;
   localparam logic [1:0] REGION_WET      = 2'd1;
   localparam logic [1:0] REGION_DRY      = 2'd2;

   localparam logic [2:0] REG_WET_EXP    = 3'd0;
   localparam logic [2:0] REG_NONWET_EXP = 3'd1;
   localparam logic [2:0] REG_WET_END    = 3'd2;
   localparam logic [2:0] REG_NONWET_END = 3'd3;
   localparam logic [2:0] REG_WET_IRR    = 3'd4;
   localparam logic [2:0] REG_NONWET_IRR = 3'd5;

   // Floor square root of a value below 2^60; elaboration use only.
   function automatic logic [63:0] isqrt60(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int i = 29; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // Q2.30 value of 2^(-2^-j), built by repeated square roots of one half.
   function automatic logic [MANT_W-1:0] exp_root(input int j);
      logic [63:0] c;
      c = 64'd1 << 29;
      for (int i = 1; i <= j; i++) c = isqrt60(c << 30);
      return c[MANT_W-1:0];
   endfunction

endpackage

### src/brooks_corey_relperm_core.sv
// One beat is accepted every cycle unless a result-side stall freezes the
// pipeline. The depth is set by the divider (one quotient bit a stage) and the
// power units (24 log squarings and 24 exp2 multiplies, one stage each).
// Reset is synchronous and active high; it empties the pipeline and loads the
// register defaults (exponents 2.0, endpoints 1.0, irreducible saturations 0).
// ----------------------------------------------------------------------------
// brooks_corey_relperm_core: Brooks-Corey relative permeability top level
// Normalises each saturation, classifies its region and evaluates both phase
// power laws in a fully pipelined datapath with an APB register file.
// ----------------------------------------------------------------------------
module brooks_corey_relperm_core
   import bcr_pkg::*;
#(
   parameter int FRAC_BITS     = FRAC_BITS_DEF,
   parameter int EXP_FRAC_BITS = EXP_FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,

   // Input beats; tdata: wetting_saturation.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((FRAC_BITS+8)/8)*8-1:0]    req_tdata,

   // Result beats; tdata: wet_relperm, nonwet_relperm; tuser: region.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((2*FRAC_BITS+9)/8)*8-1:0]  rsp_tdata,
   output logic [1:0]                        rsp_tuser,

   // Register port.
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [((FRAC_BITS >= 32) ? 6 : 5)-1:0]    csr_paddr,
   input  logic [((FRAC_BITS >= 32) ? 64 : 32)-1:0]  csr_pwdata,
   output logic [((FRAC_BITS >= 32) ? 64 : 32)-1:0]  csr_prdata,
   output logic                                      csr_pready
);

   localparam int F        = FRAC_BITS;
   localparam int E        = EXP_FRAC_BITS;
   localparam int EXPW     = E + 4;
   localparam int CSR_W    = (F >= 32) ? 64 : 32;
   localparam int ADDR_W   = (F >= 32) ? 6 : 5;
   localparam int ADDR_LSB = ADDR_W - 3;
   localparam int TDATA_W  = ((2*F+9)/8)*8;
   localparam int DLY      = F + POW_LAT;
   localparam logic [F:0] UNIT = {1'b1, {F{1'b0}}};

   typedef struct packed {
      logic       valid;
      logic [1:0] region;
   } side_type;

   // ------------------------------------------------------------------------
   // Register file. Writes land on the access cycle; reads are combinational.
   // ------------------------------------------------------------------------
   logic [EXPW-1:0] wexp_ff, nexp_ff;
   logic [F:0]      wend_ff, nend_ff;
   logic [F-1:0]    wirr_ff, nirr_ff;
   logic [2:0]      csr_index;
   logic            csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[ADDR_W-1:ADDR_LSB];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wexp_ff <= EXPW'(2) << E;
         nexp_ff <= EXPW'(2) << E;
         wend_ff <= UNIT;
         nend_ff <= UNIT;
         wirr_ff <= '0;
         nirr_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_WET_EXP:    wexp_ff <= csr_pwdata[EXPW-1:0];
            REG_NONWET_EXP: nexp_ff <= csr_pwdata[EXPW-1:0];
            REG_WET_END:    wend_ff <= csr_pwdata[F:0];
            REG_NONWET_END: nend_ff <= csr_pwdata[F:0];
            REG_WET_IRR:    wirr_ff <= csr_pwdata[F-1:0];
            REG_NONWET_IRR: nirr_ff <= csr_pwdata[F-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WET_EXP:    csr_prdata = CSR_W'(wexp_ff);
         REG_NONWET_EXP: csr_prdata = CSR_W'(nexp_ff);
         REG_WET_END:    csr_prdata = CSR_W'(wend_ff);
         REG_NONWET_END: csr_prdata = CSR_W'(nend_ff);
         REG_WET_IRR:    csr_prdata = CSR_W'(wirr_ff);
         REG_NONWET_IRR: csr_prdata = CSR_W'(nirr_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // Endpoints above 1.0 are clamped before they are used anywhere.
   logic [F:0] wend_sat, nend_sat;
   assign wend_sat = (wend_ff > UNIT) ? UNIT : wend_ff;
   assign nend_sat = (nend_ff > UNIT) ? UNIT : nend_ff;

   // ------------------------------------------------------------------------
   // The whole pipeline advances together whenever the output register is
   // free or being drained, so a stall freezes every stage in place.
   // ------------------------------------------------------------------------
   logic ce;
   logic rsp_valid_ff;

   assign ce         = !rsp_valid_ff || rsp_tready;
   assign req_tready = ce;

   // ------------------------------------------------------------------------
   // Classification stage. The numerator and denominator are exact signed
   // values; a non-positive denominator counts as fully wet.
   // ------------------------------------------------------------------------
   logic [F:0]          sw;
   logic signed [F+1:0] num_s, den_s;
   logic [1:0]          region_in;
   logic [F:0]          num_ff;
   side_type            side_ff [DLY+1];

   assign sw    = req_tdata[F:0];
   assign num_s = $signed({1'b0, sw}) - $signed({2'b00, wirr_ff});
   assign den_s = $signed({1'b0, UNIT}) - $signed({2'b00, wirr_ff})
                  - $signed({2'b00, nirr_ff});

   always_comb begin
      if (den_s <= 0 || num_s >= den_s) begin
         region_in = REGION_WET;
      end else if (num_s <= 0) begin
         region_in = REGION_DRY;
      end else begin
         region_in = REGION_INTERIOR;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) num_ff <= (region_in == REGION_INTERIOR) ? num_s[F:0] : (F+1)'(1);
   end

   // Valid and region ride alongside the datapath on their own delay line.
   for (genvar i = 0; i <= DLY; i++) begin : g_side
      side_type side_prev;

      if (i == 0) begin : g_first
         assign side_prev = {req_tvalid, region_in};
      end else begin : g_next
         assign side_prev = side_ff[i-1];
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            side_ff[i].region <= side_prev.region;
         end
         if (reset) begin
            side_ff[i].valid <= 1'b0;
         end else if (ce) begin
            side_ff[i].valid <= side_prev.valid;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Normalised saturation and the two power laws.
   // ------------------------------------------------------------------------
   logic [F-1:0] s_norm, s_comp;
   logic [F:0]   wet_pow, nonwet_pow;

   bcr_div #(
      .FRAC_BITS (F)
   ) u_div (
      .clock (clock),
      .ce    (ce),
      .num   (num_ff),
      .den   (den_s[F:0]),
      .quo   (s_norm)
   );

   // 1 - s; s lies strictly inside (0, 1) here, so the wrap is exact.
   assign s_comp = '0 - s_norm;

   bcr_pow #(
      .FRAC_BITS     (F),
      .EXP_FRAC_BITS (E)
   ) u_pow_wet (
      .clock    (clock),
      .ce       (ce),
      .base     (s_norm),
      .expo     (wexp_ff),
      .endpoint (wend_sat),
      .result   (wet_pow)
   );

   bcr_pow #(
      .FRAC_BITS     (F),
      .EXP_FRAC_BITS (E)
   ) u_pow_nonwet (
      .clock    (clock),
      .ce       (ce),
      .base     (s_comp),
      .expo     (nexp_ff),
      .endpoint (nend_sat),
      .result   (nonwet_pow)
   );

   // ------------------------------------------------------------------------
   // Output register: the end regions bypass the power results.
   // ------------------------------------------------------------------------
   logic [F:0] wet_ff, nonwet_ff;
   logic [1:0] region_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ce) begin
         rsp_valid_ff <= side_ff[DLY].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         region_ff <= side_ff[DLY].region;
         case (side_ff[DLY].region)
            REGION_WET: begin
               wet_ff    <= wend_sat;
               nonwet_ff <= '0;
            end
            REGION_DRY: begin
               wet_ff    <= '0;
               nonwet_ff <= nend_sat;
            end
            default: begin
               wet_ff    <= wet_pow;
               nonwet_ff <= nonwet_pow;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'({nonwet_ff, wet_ff});
   assign rsp_tuser  = region_ff;

`ifndef SYNTHESIS
   a_wet_zero_nonwet : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == REGION_WET |-> nonwet_ff == '0)
      else $error("fully wet result carries a non-wetting value");

   a_dry_zero_wet : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == REGION_DRY |-> wet_ff == '0)
      else $error("irreducible result carries a wetting value");

   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> wet_ff <= UNIT && nonwet_ff <= UNIT)
      else $error("relative permeability above one");

   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat present straight after reset");
`endif

endmodule

### src/bcr_div.sv
// ----------------------------------------------------------------------------
// bcr_div: pipelined restoring divider
// Forms floor(num * 2^F / den) for 0 < num < den, one quotient bit a stage.
// ----------------------------------------------------------------------------
module bcr_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 ce,
   input  logic [FRAC_BITS:0]   num,
   input  logic [FRAC_BITS:0]   den,
   output logic [FRAC_BITS-1:0] quo
);

   localparam int F = FRAC_BITS;

   logic [F:0]   r_ff [F];
   logic [F-1:0] q_ff [F];

   for (genvar i = 0; i < F; i++) begin : g_step
      logic [F:0]   r_prev;
      logic [F-1:0] q_prev;
      logic [F+1:0] r_sh;
      logic [F+1:0] r_sub;
      logic [F:0]   r_in;
      logic [F-1:0] q_in;

      if (i == 0) begin : g_first
         assign r_prev = num;
         assign q_prev = '0;
      end else begin : g_next
         assign r_prev = r_ff[i-1];
         assign q_prev = q_ff[i-1];
      end

      always_comb begin
         r_sh  = {r_prev, 1'b0};
         r_sub = r_sh - {1'b0, den};
         if (r_sh >= {1'b0, den}) begin
            r_in = r_sub[F:0];
            q_in = {q_prev[F-2:0], 1'b1};
         end else begin
            r_in = r_sh[F:0];
            q_in = {q_prev[F-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            r_ff[i] <= r_in;
            q_ff[i] <= q_in;
         end
      end
   end

   assign quo = q_ff[F-1];

endmodule

### src/bcr_pow.sv
// ----------------------------------------------------------------------------
// bcr_pow: pipelined fixed-point power and endpoint scaling
// endpoint * base^expo through a squaring log2, one exponent product and a
// chain of constant-root exp2 multiplies, all one stage per step.
// ----------------------------------------------------------------------------
module bcr_pow
   import bcr_pkg::*;
#(
   parameter int FRAC_BITS     = FRAC_BITS_DEF,
   parameter int EXP_FRAC_BITS = EXP_FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     ce,
   input  logic [FRAC_BITS-1:0]     base,
   input  logic [EXP_FRAC_BITS+3:0] expo,
   input  logic [FRAC_BITS:0]       endpoint,
   output logic [FRAC_BITS:0]       result
);

   localparam int F    = FRAC_BITS;
   localparam int E    = EXP_FRAC_BITS;
   localparam int EXPW = E + 4;
   localparam int IP_W = $clog2(F + 1);
   localparam int LW   = IP_W + LOG_BITS;
   localparam int PW   = EXPW + LW;
   localparam int KW   = PW - E - LOG_BITS;
   localparam int ACCW = MANT_FRAC + 1;

   // Log section: index 0 is the normalise stage.
   logic [MANT_W-1:0]   m_ff  [LOG_BITS+1];
   logic [LOG_BITS-1:0] fr_ff [LOG_BITS+1];
   logic [IP_W-1:0]     ip_ff [LOG_BITS+1];

   // Exp section: index 0 is the exponent product stage.
   logic [ACCW-1:0]     acc_ff [LOG_BITS+1];
   logic [LOG_BITS-1:0] f_ff   [LOG_BITS+1];
   logic [5:0]          k_ff   [LOG_BITS+1];

   logic [F:0] pw_ff;
   logic [F:0] res_ff;

   // Normalise: leading one to bit 30.
   logic [IP_W-1:0]   lead;
   logic [63:0]       wide;
   logic [MANT_W-1:0] m_norm;

   always_comb begin
      lead = '0;
      for (int i = 0; i < F; i++) begin
         if (base[i]) lead = IP_W'(i);
      end
      wide = 64'(base);
      if (lead <= IP_W'(MANT_FRAC)) begin
         wide = wide << (6'(MANT_FRAC) - 6'(lead));
      end else begin
         wide = wide >> (6'(lead) - 6'(MANT_FRAC));
      end
      m_norm = wide[MANT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         m_ff[0]  <= m_norm;
         fr_ff[0] <= '0;
         ip_ff[0] <= IP_W'(F) - lead;
      end
   end

   for (genvar j = 0; j < LOG_BITS; j++) begin : g_log
      logic [63:0]       sq_full;
      logic [MANT_W-1:0] sq;
      logic [MANT_W-1:0] m_in;

      always_comb begin
         sq_full = 64'(m_ff[j]) * 64'(m_ff[j]);
         sq      = sq_full[MANT_FRAC+MANT_W-1:MANT_FRAC];
         m_in    = sq[MANT_W-1] ? (sq >> 1) : sq;
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            m_ff[j+1]  <= m_in;
            fr_ff[j+1] <= {fr_ff[j][LOG_BITS-2:0], sq[MANT_W-1]};
            ip_ff[j+1] <= ip_ff[j];
         end
      end
   end

   // Exponent product: Y = (n * -log2 x) >> E.
   logic [LW-1:0] lval;
   logic [PW-1:0] prod_y;
   logic [KW-1:0] kfull;
   logic [5:0]    ksat;

   always_comb begin
      lval   = {ip_ff[LOG_BITS], {LOG_BITS{1'b0}}} - LW'(fr_ff[LOG_BITS]);
      prod_y = PW'(expo) * PW'(lval);
      kfull  = prod_y[PW-1:E+LOG_BITS];
      ksat   = (kfull > KW'(63)) ? 6'd63 : kfull[5:0];
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         acc_ff[0] <= ACCW'(1) << MANT_FRAC;
         f_ff[0]   <= prod_y[E+LOG_BITS-1:E];
         k_ff[0]   <= ksat;
      end
   end

   for (genvar j = 1; j <= LOG_BITS; j++) begin : g_exp
      localparam logic [MANT_W-1:0] ROOT = exp_root(j);
      logic [63:0]     prod_e;
      logic [ACCW-1:0] acc_in;

      always_comb begin
         prod_e = 64'(acc_ff[j-1]) * 64'(ROOT);
         acc_in = f_ff[j-1][LOG_BITS-j] ? prod_e[MANT_FRAC+ACCW-1:MANT_FRAC]
                                        : acc_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            acc_ff[j] <= acc_in;
            f_ff[j]   <= f_ff[j-1];
            k_ff[j]   <= k_ff[j-1];
         end
      end
   end

   // Back from Q2.30 to Q.F, then right by the integer part of Y.
   logic [ACCW+F-1:0] shifted;

   always_comb begin
      shifted = {acc_ff[LOG_BITS], {F{1'b0}}} >> (7'(MANT_FRAC) + 7'(k_ff[LOG_BITS]));
   end

   always_ff @(posedge clock) begin
      if (ce) pw_ff <= shifted[F:0];
   end

   logic [2*F+1:0] prod_s;

   always_comb begin
      prod_s = (2*F+2)'(endpoint) * (2*F+2)'(pw_ff);
   end

   always_ff @(posedge clock) begin
      if (ce) res_ff <= pw_ff[F] ? endpoint : prod_s[2*F:F];
   end

   assign result = res_ff;

endmodule

### tb/brooks_corey_relperm_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brooks_corey_relperm_core_test: self-checking regression of the core
// Drives saturation beats through the stream input, writes the register file
// between phases over the APB port and compares every result beat, field by
// field, with typed-in answers or an in-bench fixed-point Brooks-Corey predictor.
// ----------------------------------------------------------------------------
module brooks_corey_relperm_core_test;
   import bcr_pkg::*;

   localparam int F      = FRAC_BITS_DEF;
   localparam int UNIT   = 1 << F;
   // Headroom after the last result before the final verdict, and before any
   // register write once the result queue has drained.
   localparam int SETTLE = F + 53 + 20;

   typedef struct packed {
      logic [F:0] wet;
      logic [F:0] nonwet;
      logic [1:0] region;
   } relperm_type;

   // One row of the directed table. When known is set the expected beat is
   // typed in; otherwise the predictor supplies it.
   typedef struct {
      logic [F:0]  sat;
      bit          known;
      relperm_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;    // [16:0] wetting_saturation
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [16:0] wet_relperm, [33:17] nonwet_relperm
   logic [1:0]  rsp_tuser;    // [1:0] region
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Shadow of the register file, kept at the register widths.
   logic [15:0] wet_exp_q, nonwet_exp_q;
   logic [F:0]  wet_end_q, nonwet_end_q;
   logic [F-1:0] wet_irr_q, nonwet_irr_q;

   logic [63:0] half_roots [1:LOG_BITS];
   relperm_type pending_relperm [$];
   int          mismatch_count;
   bit          hold_req;
   bit          no_gaps;

   brooks_corey_relperm_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Generous ceiling: the slowest legal run is a few hundred thousand ns.
   initial begin
      #20ms;
      $display("brooks_corey_relperm_core regression: fail");
      $finish;
   end

   // Floor square root by bit-by-bit trial, used to build the exp2 roots.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = '0;
      for (int i = 29; i >= 0; i--) begin
         t = r | (64'd1 << i);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   // x^n for x a Q0.F fraction and n a Q4.12 exponent: the core's log2/exp2
   // scheme with 24 squaring steps and 24 root multiplies.
   function automatic logic [63:0] frac_power(input logic [63:0] x, input logic [63:0] n);
      int          lead;
      logic [63:0] m, frac, lg, y, f, k, acc, sh;
      lead = 0;
      for (int j = 0; j < 64; j++) if (x[j]) lead = j;
      m = (lead <= 30) ? (x << (30 - lead)) : (x >> (lead - 30));
      frac = '0;
      for (int j = 0; j < LOG_BITS; j++) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m = m >> 1;
            frac = (frac << 1) | 64'd1;
         end else begin
            frac = frac << 1;
         end
      end
      lg = (64'(F - lead) << LOG_BITS) - frac;
      y = (n * lg) >> EXP_FRAC_BITS_DEF;
      k = y >> LOG_BITS;
      f = y & ((64'd1 << LOG_BITS) - 1);
      acc = 64'd1 << 30;
      for (int j = 1; j <= LOG_BITS; j++)
         if (f[LOG_BITS-j]) acc = (acc * half_roots[j]) >> 30;
      sh = k + 64'(30 - F);
      return (sh >= 64) ? 64'd0 : (acc >> sh);
   endfunction

   function automatic logic [63:0] clip_endpoint(input logic [63:0] e);
      return (e > UNIT) ? 64'(UNIT) : e;
   endfunction

   function automatic logic [63:0] apply_endpoint(input logic [63:0] e, input logic [63:0] pw);
      logic [63:0] ce;
      ce = clip_endpoint(e);
      if (pw >= UNIT) return ce;
      return (ce * pw) >> F;
   endfunction

   // Expected relative permeabilities for one saturation under the shadow
   // register values.
   function automatic relperm_type predict_relperm(input logic [F:0] sat);
      longint      num, den;
      logic [63:0] r, d, s;
      relperm_type res;
      num = longint'(sat) - longint'(wet_irr_q);
      den = longint'(UNIT) - longint'(wet_irr_q) - longint'(nonwet_irr_q);
      if (den <= 0 || num >= den) begin
         res.wet    = (F+1)'(clip_endpoint(64'(wet_end_q)));
         res.nonwet = '0;
         res.region = REGION_WET;
      end else if (num <= 0) begin
         res.wet    = '0;
         res.nonwet = (F+1)'(clip_endpoint(64'(nonwet_end_q)));
         res.region = REGION_DRY;
      end else begin
         // Restoring division gives the normalised saturation in Q0.F.
         r = 64'(num);
         d = 64'(den);
         s = '0;
         for (int i = 0; i < F; i++) begin
            r = r << 1;
            s = s << 1;
            if (r >= d) begin
               r = r - d;
               s = s | 64'd1;
            end
         end
         res.wet    = (F+1)'(apply_endpoint(64'(wet_end_q),
                                            frac_power(s, 64'(wet_exp_q))));
         res.nonwet = (F+1)'(apply_endpoint(64'(nonwet_end_q),
                                            frac_power(64'(UNIT) - s, 64'(nonwet_exp_q))));
         res.region = REGION_INTERIOR;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   // Mostly back-to-back, sometimes a short gap, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(20, 70);
   endfunction

   // Register write: setup cycle, then access cycle, then idle so that
   // consecutive writes never overlap. The shadow copy is updated with
   // the bits the core keeps.
   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_WET_EXP:    wet_exp_q    = value[15:0];
         REG_NONWET_EXP: nonwet_exp_q = value[15:0];
         REG_WET_END:    wet_end_q    = value[F:0];
         REG_NONWET_END: nonwet_end_q = value[F:0];
         REG_WET_IRR:    wet_irr_q    = value[F-1:0];
         REG_NONWET_IRR: nonwet_irr_q = value[F-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offers one saturation beat and records its expectation on acceptance.
   task automatic send_saturation(input logic [F:0] sat, input bit known, input relperm_type want);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {7'($urandom_range(0, 127)), sat};  // upper pad bits are don't-care
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_relperm.push_back(known ? want : predict_relperm(sat));
      gap = no_gaps ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits for every expected beat, then lets the pipeline settle so that a
   // register write cannot overtake work in flight.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_relperm.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Saturations are mostly drawn near the interesting band above the wet
   // irreducible value; the rest cover the whole 17-bit field.
   function automatic logic [F:0] pick_saturation();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 6) return (F+1)'($urandom_range(wet_irr_q, UNIT - nonwet_irr_q));
      if (roll < 7) return (F+1)'($urandom_range(0, 3) + wet_irr_q);
      return (F+1)'($urandom_range(0, 2 * UNIT - 1));
   endfunction

   task automatic random_phase(input int count);
      relperm_type none;
      none = '0;
      for (int i = 0; i < count; i++) send_saturation(pick_saturation(), 1'b0, none);
   endtask

   task automatic write_all(input logic [31:0] wexp, input logic [31:0] nexp,
                            input logic [31:0] wend, input logic [31:0] nend,
                            input logic [31:0] wirr, input logic [31:0] nirr);
      csr_write(REG_WET_EXP,    wexp);
      csr_write(REG_NONWET_EXP, nexp);
      csr_write(REG_WET_END,    wend);
      csr_write(REG_NONWET_END, nend);
      csr_write(REG_WET_IRR,    wirr);
      csr_write(REG_NONWET_IRR, nirr);
   endtask

   // Result checker: every accepted beat is compared with the oldest
   // expectation, field by field.
   always @(posedge clock) begin
      relperm_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_relperm.size() == 0) begin
            report_mismatch("result beat with no saturation outstanding");
         end else begin
            want = pending_relperm.pop_front();
            if (rsp_tdata[16:0] !== want.wet)
               report_mismatch($sformatf("wet_relperm %0d, expected %0d",
                                         rsp_tdata[16:0], want.wet));
            if (rsp_tdata[33:17] !== want.nonwet)
               report_mismatch($sformatf("nonwet_relperm %0d, expected %0d",
                                         rsp_tdata[33:17], want.nonwet));
            if (rsp_tuser !== want.region)
               report_mismatch($sformatf("region %0d, expected %0d",
                                         rsp_tuser, want.region));
         end
      end
   end

   // Result-side back-pressure. A long hold, when asked for, keeps tready low
   // well beyond the pipeline depth so that the core has to stall its input.
   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   // Main sequence.
   initial begin
      stim_row_type directed [$];
      relperm_type  none;
      logic [63:0]  c;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      mismatch_count = 0;
      hold_req = 1'b0;
      no_gaps  = 1'b0;
      none = '0;

      // Reset values of the register file.
      wet_exp_q    = 16'd2 << EXP_FRAC_BITS_DEF;
      nonwet_exp_q = 16'd2 << EXP_FRAC_BITS_DEF;
      wet_end_q    = UNIT;
      nonwet_end_q = UNIT;
      wet_irr_q    = '0;
      nonwet_irr_q = '0;

      // Q2.30 roots 2^(-2^-j) for the exp2 multiplies.
      c = 64'd1 << 29;
      for (int j = 1; j <= LOG_BITS; j++) begin
         c = floor_sqrt(c << 30);
         half_roots[j] = c;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table under the reset settings: the region boundaries and
      // saturations above 1.0 have their answers typed in, the interior rows
      // go through the predictor.
      directed.push_back('{17'd0,       1'b1, '{17'd0,      17'd65536, REGION_DRY}});
      directed.push_back('{17'd65536,   1'b1, '{17'd65536,  17'd0,     REGION_WET}});
      directed.push_back('{17'h1FFFF,   1'b1, '{17'd65536,  17'd0,     REGION_WET}});
      directed.push_back('{17'd65537,   1'b1, '{17'd65536,  17'd0,     REGION_WET}});
      directed.push_back('{17'd1,       1'b0, none});
      directed.push_back('{17'd2,       1'b0, none});
      directed.push_back('{17'd256,     1'b0, none});
      directed.push_back('{17'd32768,   1'b0, none});
      directed.push_back('{17'd49152,   1'b0, none});
      directed.push_back('{17'd65534,   1'b0, none});
      directed.push_back('{17'd65535,   1'b0, none});
      directed.push_back('{17'h0AAAA,   1'b0, none});
      directed.push_back('{17'h15555,   1'b1, '{17'd65536,  17'd0,     REGION_WET}});
      foreach (directed[i])
         send_saturation(directed[i].sat, directed[i].known, directed[i].want);
      random_phase(100);
      drain_results();

      // Every exponent zero: the interior answers are exactly the endpoints.
      // Endpoints above 1.0 are clipped; pad bits of the exponent writes are ignored.
      write_all(32'hFFFF_0000, 32'h1234_0000, 32'hFFFF_FFFF, 32'h0001_FFFF,
                32'h0000_0100, 32'h0000_0200);
      send_saturation(17'd0, 1'b1, '{17'd0, 17'd65536, REGION_DRY});
      send_saturation(17'h1FFFF, 1'b1, '{17'd65536, 17'd0, REGION_WET});
      random_phase(100);
      drain_results();

      // Largest exponents with zero endpoints, then the reverse.
      write_all(32'h0000_FFFF, 32'h0000_FFFF, 32'd0, 32'd0, 32'd1, 32'd1);
      random_phase(80);
      drain_results();
      write_all(32'd1, 32'd1, 32'd65536, 32'd65536, 32'd0, 32'd0);
      random_phase(80);
      drain_results();

      // Irreducible saturations summing past 1.0: the denominator is not
      // positive, so every beat lands in the fully wet region.
      write_all(32'd8192, 32'd8192, 32'd40000, 32'd30000, 32'h0000_FFFF, 32'h0000_FFFF);
      send_saturation(17'd0, 1'b1, '{17'd40000, 17'd0, REGION_WET});
      random_phase(30);
      drain_results();

      // A long result-side hold with back-to-back input: the core fills up
      // and must push back on its input.
      write_all(32'd6144, 32'd10240, 32'd50000, 32'd60000, 32'd3000, 32'd5000);
      no_gaps  = 1'b1;
      hold_req = 1'b1;
      random_phase(150);
      no_gaps = 1'b0;
      drain_results();

      // Random settings, with the irreducible values kept mostly modest.
      for (int ph = 0; ph < 6; ph++) begin
         write_all($urandom, $urandom, $urandom_range(0, 2 * UNIT - 1),
                   $urandom_range(0, 2 * UNIT - 1),
                   (ph == 5) ? $urandom : $urandom_range(0, 20000),
                   (ph == 5) ? $urandom : $urandom_range(0, 20000));
         random_phase(65);
         drain_results();
      end

      if (mismatch_count == 0) begin
         $display("brooks_corey_relperm_core regression: pass");
      end else begin
         $display("brooks_corey_relperm_core regression: fail");
      end
      $finish;
   end

endmodule

### brooks_corey_relperm_core.f
src/bcr_pkg.sv
src/bcr_div.sv
src/bcr_pow.sv
src/brooks_corey_relperm_core.sv
tb/brooks_corey_relperm_core_test.sv
